>>> hw/rtl/fsc_pkg.sv
// shared types, constants and tables for the flash save command machine
package fsc_pkg;

   // store geometry
   localparam int BANK_COUNT   = 2;
   localparam int BANK_BYTES   = 65536;
   localparam int SECTOR_BYTES = 4096;
   localparam int OFFSET_W     = 16;
   localparam int SECTOR_W     = $clog2(SECTOR_BYTES);
   localparam int BANK_W       = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
   localparam int ADDR_W       = OFFSET_W + BANK_W;
   localparam int STORE_BYTES  = BANK_COUNT * BANK_BYTES;
   localparam int BASE_W       = ADDR_W - SECTOR_W;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [BANK_W-1:0] bank_type;
   typedef bank_type [255:0]  bank_table_type;

   localparam addr_type LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

   // access kinds
   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // unlock addresses and bytes
   localparam logic [OFFSET_W-1:0] ADDR_FIRST  = 16'h5555;
   localparam logic [OFFSET_W-1:0] ADDR_SECOND = 16'h2AAA;
   localparam logic [OFFSET_W-1:0] OFFSET_MFR  = 16'h0000;
   localparam logic [OFFSET_W-1:0] OFFSET_DEV  = 16'h0001;
   localparam logic [7:0] BYTE_UNLOCK1 = 8'hAA;
   localparam logic [7:0] BYTE_UNLOCK2 = 8'h55;
   localparam logic [7:0] BYTE_ERASED  = 8'hFF;

   // command bytes
   localparam logic [7:0] CMD_NONE         = 8'h00;
   localparam logic [7:0] CMD_ERASE        = 8'h80;
   localparam logic [7:0] CMD_ID           = 8'h90;
   localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
   localparam logic [7:0] CMD_BANK         = 8'hB0;
   localparam logic [7:0] CMD_RESET        = 8'hF0;
   localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;

   // configuration registers
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MANUFACTURER_ID = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ID       = 1'd1;
   localparam logic [7:0] MANUFACTURER_ID_RESET = 8'd50;
   localparam logic [7:0] DEVICE_ID_RESET       = 8'd27;

   // memory command from the sequencer to the store
   typedef struct packed {
      logic     prog;
      logic     erase;
      addr_type addr;
      logic [7:0] data;
   } mem_cmd_type;

   // how the response byte of an item is formed
   typedef struct packed {
      logic       use_mem;
      logic [7:0] alt_byte;
   } rsp_sel_type;

   // bank number of a written byte, modulo the bank count
   function automatic bank_table_type build_bank_table();
      bank_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[i] = BANK_W'(i % BANK_COUNT);
      end
      return t;
   endfunction

   localparam bank_table_type BANK_TABLE = build_bank_table();

endpackage

>>> hw/rtl/fsc_store.sv
// banked byte store with reset clearing pass and sector erase sweep
module fsc_store (
   input  logic                 clock,
   input  logic                 reset,
   input  fsc_pkg::mem_cmd_type mem_cmd,
   input  fsc_pkg::addr_type    rd_addr,
   output logic [7:0]           rd_data,
   output logic                 busy
);
   import fsc_pkg::*;

   typedef enum logic [2:0] {
      SW_IDLE  = 3'b001,
      SW_CLEAR = 3'b010,
      SW_ERASE = 3'b100
   } sweep_state_type;

   logic [7:0] store_mem_ff [STORE_BYTES];
   logic [7:0] rd_data_ff;

   sweep_state_type sw_state_ff, sw_state_in;
   addr_type        sweep_cnt_ff, sweep_cnt_in;
   logic [BASE_W-1:0] erase_base_ff, erase_base_in;

   logic       wr_en;
   addr_type   wr_addr;
   logic [7:0] wr_data;

   // sweep sequencing
   always_comb begin
      sw_state_in   = sw_state_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      erase_base_in = erase_base_ff;
      case (sw_state_ff)
         SW_CLEAR: begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff == LAST_ADDR) begin
               sw_state_in = SW_IDLE;
            end
         end
         SW_ERASE: begin
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_cnt_ff[SECTOR_W-1:0] == {SECTOR_W{1'b1}}) begin
               sw_state_in = SW_IDLE;
            end
         end
         default: begin
            if (mem_cmd.erase) begin
               sw_state_in   = SW_ERASE;
               sweep_cnt_in  = '0;
               erase_base_in = mem_cmd.addr[ADDR_W-1:SECTOR_W];
            end
         end
      endcase
   end

   // write port select: sweeps own the port while busy
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = mem_cmd.addr;
      wr_data = mem_cmd.data;
      case (sw_state_ff)
         SW_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = sweep_cnt_ff;
            wr_data = BYTE_ERASED;
         end
         SW_ERASE: begin
            wr_en   = 1'b1;
            wr_addr = {erase_base_ff, sweep_cnt_ff[SECTOR_W-1:0]};
            wr_data = BYTE_ERASED;
         end
         default: begin
            wr_en = mem_cmd.prog;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_state_ff  <= SW_CLEAR;
         sweep_cnt_ff <= '0;
      end else begin
         sw_state_ff  <= sw_state_in;
         sweep_cnt_ff <= sweep_cnt_in;
      end
      erase_base_ff <= erase_base_in;
   end

   // memory array, one write and one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign busy    = (sw_state_ff != SW_IDLE);

   // no program or erase request may arrive while a sweep owns the port
   a_prog_idle: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.prog |-> sw_state_ff == SW_IDLE)
      else $error("program write during sweep");
   a_erase_idle: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.erase |-> sw_state_ff == SW_IDLE)
      else $error("erase request during sweep");
   a_erase_start: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.erase |=> sw_state_ff == SW_ERASE && sweep_cnt_ff == '0)
      else $error("erase sweep did not start");

endmodule

>>> hw/rtl/fsc_seq.sv
// command sequence decoder with pending command, bank and id registers
module fsc_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic                              req_opcode,
   input  logic [fsc_pkg::OFFSET_W-1:0]      req_offset,
   input  logic [7:0]                        req_write_byte,
   input  logic                              csr_write_enable,
   input  logic [fsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [7:0]                        csr_write_data,
   output fsc_pkg::mem_cmd_type              mem_cmd,
   output fsc_pkg::addr_type                 rd_addr,
   output fsc_pkg::rsp_sel_type              rsp_sel
);
   import fsc_pkg::*;

   typedef enum logic [8:0] {
      SEQ_IDLE    = 9'b000000001,
      SEQ_UNLOCK1 = 9'b000000010,
      SEQ_UNLOCK2 = 9'b000000100,
      SEQ_ERASE0  = 9'b000001000,
      SEQ_ERASE1  = 9'b000010000,
      SEQ_ERASE2  = 9'b000100000,
      SEQ_ID0     = 9'b001000000,
      SEQ_ID1     = 9'b010000000,
      SEQ_ID2     = 9'b100000000
   } seq_state_type;

   seq_state_type seq_ff, seq_in;
   logic [7:0]    pend_ff, pend_in;
   bank_type      bank_ff, bank_in;
   logic [7:0]    mfr_id_ff, dev_id_ff;

   logic at_first, at_second, at_zero;
   logic is_unlock1, is_unlock2;
   logic fall, prog, erase;

   assign at_first   = (req_offset == ADDR_FIRST);
   assign at_second  = (req_offset == ADDR_SECOND);
   assign at_zero    = (req_offset == OFFSET_MFR);
   assign is_unlock1 = at_first && (req_write_byte == BYTE_UNLOCK1);
   assign is_unlock2 = at_second && (req_write_byte == BYTE_UNLOCK2);

   // response byte for a read
   always_comb begin
      rsp_sel.use_mem  = 1'b0;
      rsp_sel.alt_byte = BYTE_ERASED;
      if (req_opcode == OP_READ) begin
         if (pend_ff == CMD_NONE) begin
            rsp_sel.use_mem = 1'b1;
         end else if (pend_ff == CMD_ID) begin
            if (req_offset == OFFSET_MFR) begin
               rsp_sel.alt_byte = mfr_id_ff;
            end else if (req_offset == OFFSET_DEV) begin
               rsp_sel.alt_byte = dev_id_ff;
            end
         end
      end
   end

   // sequence state update
   always_comb begin
      seq_in  = seq_ff;
      pend_in = pend_ff;
      bank_in = bank_ff;
      fall    = 1'b0;
      prog    = 1'b0;
      erase   = 1'b0;
      if (accept && req_opcode == OP_WRITE) begin
         case (seq_ff)
            SEQ_UNLOCK1: begin
               if (is_unlock2) begin
                  seq_in = SEQ_UNLOCK2;
               end else begin
                  seq_in = SEQ_IDLE;
                  fall   = 1'b1;
               end
            end
            SEQ_UNLOCK2: begin
               if (at_first) begin
                  pend_in = req_write_byte;
                  if (req_write_byte == CMD_ERASE) begin
                     seq_in = SEQ_ERASE0;
                  end else if (req_write_byte == CMD_ID) begin
                     seq_in = SEQ_ID0;
                  end else begin
                     seq_in = SEQ_IDLE;
                  end
               end else begin
                  seq_in = SEQ_IDLE;
                  fall   = 1'b1;
               end
            end
            SEQ_ERASE0: begin
               if (is_unlock1) begin
                  seq_in = SEQ_ERASE1;
               end else begin
                  seq_in = SEQ_IDLE;
                  fall   = 1'b1;
               end
            end
            SEQ_ERASE1: begin
               if (is_unlock2) begin
                  seq_in = SEQ_ERASE2;
               end else begin
                  seq_in = SEQ_IDLE;
                  fall   = 1'b1;
               end
            end
            SEQ_ERASE2: begin
               erase   = (req_write_byte == CMD_SECTOR_ERASE);
               seq_in  = SEQ_IDLE;
               pend_in = CMD_NONE;
            end
            SEQ_ID0: begin
               if (is_unlock1) begin
                  seq_in = SEQ_ID1;
               end else begin
                  seq_in = SEQ_IDLE;
                  fall   = 1'b1;
               end
            end
            SEQ_ID1: begin
               if (is_unlock2) begin
                  seq_in = SEQ_ID2;
               end else begin
                  seq_in = SEQ_IDLE;
                  fall   = 1'b1;
               end
            end
            SEQ_ID2: begin
               seq_in  = SEQ_IDLE;
               pend_in = CMD_NONE;
            end
            default: begin
               seq_in = SEQ_IDLE;
               if (at_first && req_write_byte == CMD_RESET) begin
                  pend_in = CMD_NONE;
               end else if (is_unlock1) begin
                  seq_in = SEQ_UNLOCK1;
               end else if (at_zero && pend_ff == CMD_BANK) begin
                  bank_in = BANK_TABLE[req_write_byte];
                  pend_in = CMD_NONE;
               end else begin
                  fall = 1'b1;
               end
            end
         endcase
         // an unconsumed write programs one byte when armed
         if (fall && pend_ff == CMD_PROGRAM) begin
            prog    = 1'b1;
            seq_in  = SEQ_IDLE;
            pend_in = CMD_NONE;
         end
      end else if (accept && pend_ff == CMD_RESET) begin
         // read under a pending reset clears the sequence
         seq_in  = SEQ_IDLE;
         pend_in = CMD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= SEQ_IDLE;
         pend_ff   <= CMD_NONE;
         bank_ff   <= '0;
         mfr_id_ff <= MANUFACTURER_ID_RESET;
         dev_id_ff <= DEVICE_ID_RESET;
      end else begin
         seq_ff  <= seq_in;
         pend_ff <= pend_in;
         bank_ff <= bank_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MANUFACTURER_ID: mfr_id_ff <= csr_write_data;
               CSR_DEVICE_ID:       dev_id_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   assign rd_addr       = {bank_ff, req_offset};
   assign mem_cmd.prog  = prog;
   assign mem_cmd.erase = erase;
   assign mem_cmd.addr  = {bank_ff, req_offset};
   assign mem_cmd.data  = req_write_byte;

   // bank number stays below the bank count
   a_bank_range: assert property (@(posedge clock) disable iff (reset)
      bank_ff <= BANK_W'(BANK_COUNT - 1))
      else $error("bank out of range");
   // a program clears the pending command and the sequence
   a_prog_clears: assert property (@(posedge clock) disable iff (reset)
      prog |=> pend_ff == CMD_NONE && seq_ff == SEQ_IDLE)
      else $error("program did not clear the command");
   // program and erase never come from the same item
   a_one_mem_op: assert property (@(posedge clock) disable iff (reset)
      !(prog && erase))
      else $error("program and erase together");

endmodule

>>> hw/rtl/flash_save_command_machine.sv
// flash save command machine: for every item, accept is registered in s1_valid_ff and then in rsp_strobe_ff
// throughput: one item per cycle while busy is low; reads use the store's registered read port
// a sector erase holds busy high while the store sweeps the sector's 4096 bytes to the erased byte
// after reset busy stays high for a clearing pass over all BANK_COUNT * 65536 bytes (131072 here)
// configuration registers reset to 50 and 27; results cannot be stalled by the receiver
module flash_save_command_machine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_opcode,
   input  logic [fsc_pkg::OFFSET_W-1:0]    req_offset,
   input  logic [7:0]                      req_write_byte,
   output logic                            rsp_strobe,
   output logic [7:0]                      rsp_read_byte,
   input  logic                            csr_write_enable,
   input  logic [fsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                      csr_write_data
);
   import fsc_pkg::*;

   logic        accept;
   logic        store_busy;
   mem_cmd_type mem_cmd;
   addr_type    rd_addr;
   rsp_sel_type rsp_sel;
   logic [7:0]  rd_data;

   logic        s1_valid_ff;
   rsp_sel_type s1_sel_ff;
   logic        rsp_strobe_ff;
   logic [7:0]  rsp_read_byte_ff;

   assign accept = start && !store_busy && !reset;
   assign busy   = store_busy;

   fsc_seq u_seq (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_opcode       (req_opcode),
      .req_offset       (req_offset),
      .req_write_byte   (req_write_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .mem_cmd          (mem_cmd),
      .rd_addr          (rd_addr),
      .rsp_sel          (rsp_sel)
   );

   fsc_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_cmd (mem_cmd),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .busy    (store_busy)
   );

   // response pipeline: wait for store read data, then drive the item
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_valid_ff   <= accept;
         rsp_strobe_ff <= s1_valid_ff;
      end
      s1_sel_ff        <= rsp_sel;
      rsp_read_byte_ff <= s1_sel_ff.use_mem ? rd_data : s1_sel_ff.alt_byte;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_read_byte = rsp_read_byte_ff;

   // every accepted item gives exactly one response, through s1_valid_ff and then rsp_strobe_ff
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_strobe_ff)
      else $error("missing response");
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(s1_valid_ff))
      else $error("response without item");
   // a write item always answers with the erased byte
   a_write_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_opcode == OP_WRITE) |=> ##1 rsp_read_byte_ff == BYTE_ERASED)
      else $error("write response not erased byte");

endmodule
